[rtl/cfir_pkg.sv]
package cfir_pkg;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [2:0] ADDR_TAP_COUNT = 3'd0;

    localparam int OUT_W = 32;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

[rtl/cfir_ram.sv]
module cfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/cfir_mac.sv]
module cfir_mac #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18,
    parameter int MAX_TAPS     = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cfir_pkg::mac_ctl_t                  ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]      xi,
    input  logic signed [SAMPLE_WIDTH-1:0]      xq,
    input  logic signed [COEF_WIDTH-1:0]        cr,
    input  logic signed [COEF_WIDTH-1:0]        ci,
    output logic                                out_vld,
    output logic signed [cfir_pkg::OUT_W-1:0]   out_i,
    output logic signed [cfir_pkg::OUT_W-1:0]   out_q
);

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + 2 + $clog2(MAX_TAPS);
    localparam int FRAC   = COEF_WIDTH - 2;
    localparam int EXT_W  = (ACC_W + 1 > cfir_pkg::OUT_W + 1) ? ACC_W + 1
                                                             : cfir_pkg::OUT_W + 1;
    localparam int OW     = cfir_pkg::OUT_W;

    function automatic logic signed [OW-1:0] sat_out(input logic signed [EXT_W-1:0] v);
        logic [EXT_W-OW:0] top_bits;
        top_bits = v[EXT_W-1:OW-1];
        if ((&top_bits) || !(|top_bits)) begin
            return v[OW-1:0];
        end
        return v[EXT_W-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    endfunction

    cfir_pkg::mac_ctl_t        ctl1_reg;
    logic signed [PROD_W-1:0]  p_rr_reg, p_qi_reg, p_ir_reg, p_qr_reg;
    logic signed [ACC_W-1:0]   acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0]   acc_re_next, acc_im_next;
    logic                      done2_reg, done3_reg, done4_reg;
    logic signed [ACC_W:0]     rnd_re_reg, rnd_im_reg;
    logic signed [ACC_W:0]     shf_re, shf_im;
    logic signed [EXT_W-1:0]   ext_re, ext_im;
    logic signed [OW-1:0]      out_i_reg, out_q_reg;

    always_comb begin
        acc_re_next = (ctl1_reg.first ? ACC_W'(0) : acc_re_reg)
                      + ACC_W'(p_rr_reg) - ACC_W'(p_qi_reg);
        acc_im_next = (ctl1_reg.first ? ACC_W'(0) : acc_im_reg)
                      + ACC_W'(p_ir_reg) + ACC_W'(p_qr_reg);
        shf_re = rnd_re_reg >>> FRAC;
        shf_im = rnd_im_reg >>> FRAC;
        ext_re = EXT_W'(shf_re);
        ext_im = EXT_W'(shf_im);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg  <= '0;
            done2_reg <= 1'b0;
            done3_reg <= 1'b0;
            done4_reg <= 1'b0;
        end else begin
            ctl1_reg  <= ctl;
            done2_reg <= ctl1_reg.vld && ctl1_reg.last;
            done3_reg <= done2_reg;
            done4_reg <= done3_reg;
        end
        p_rr_reg <= xi * cr;
        p_qi_reg <= xq * ci;
        p_ir_reg <= xi * ci;
        p_qr_reg <= xq * cr;
        if (ctl1_reg.vld) begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
        // round half up before the floor shift
        rnd_re_reg <= (ACC_W+1)'(acc_re_reg) + (ACC_W+1)'(1 << (FRAC - 1));
        rnd_im_reg <= (ACC_W+1)'(acc_im_reg) + (ACC_W+1)'(1 << (FRAC - 1));
        out_i_reg  <= sat_out(ext_re);
        out_q_reg  <= sat_out(ext_im);
    end

    assign out_vld = done4_reg;
    assign out_i   = out_i_reg;
    assign out_q   = out_q_reg;

endmodule

[rtl/complex_fir_filter.sv]
// Complex FIR filter with complex coefficients. An item with tuser = 0 writes one
// coefficient into the coefficient memory and gives no result; an item with tuser = 1
// pushes a sample into the delay-line memory and gives one result, the rounded, shifted
// and saturated complex sum over the newest tap_count samples (clamped to 1..MAX_TAPS;
// tap 0 takes the oldest). A sample occupies the block for one complex
// multiply-accumulate per tap, reading one delay-line and one coefficient entry per
// cycle, plus the MAC pipeline. After reset both memories are cleared over all MAX_TAPS
// entries while s_tready stays low. tap_count is written through the APB port at
// address 0 by the user only while the block is idle; the block does not enforce it.
module complex_fir_filter #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sample_i, sample_q, coef_index, coef_re, coef_im, zero pad
    input  logic [((2*SAMPLE_WIDTH+$clog2(MAX_TAPS)+2*COEF_WIDTH+7)/8)*8-1:0] s_tdata,
    // action
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_i, out_q
    output logic [2*cfir_pkg::OUT_W-1:0] m_tdata
);

    localparam int AW     = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int PW     = AW + 1;
    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = COEF_WIDTH;
    localparam int OW     = cfir_pkg::OUT_W;
    localparam int OFF_Q  = SW;
    localparam int OFF_IX = 2 * SW;
    localparam int OFF_RE = 2 * SW + AW;
    localparam int OFF_IM = 2 * SW + AW + CW;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    tap_count_reg;
    logic [AW-1:0]       clr_reg, wp_reg, pos_reg, k_reg, n_last_reg;
    logic [AW-1:0]       wpn, pos_start, n_last;
    logic [CNT_W-1:0]    nsat, nm1;
    logic [PW-1:0]       wpn_e, n_e, pos_e;
    logic                accept, take_sample, take_load, cfg_wr;
    logic [AW-1:0]       in_idx;

    logic                line_we, coef_we;
    logic [AW-1:0]       line_waddr, coef_waddr;
    logic [2*SW-1:0]     line_wdata, line_rdata;
    logic [2*CW-1:0]     coef_wdata, coef_rdata;

    cfir_pkg::mac_ctl_t  issue_ctl, ctl_d_reg;
    logic                mac_vld;
    logic signed [OW-1:0] mac_i, mac_q;

    logic                res_vld_reg, m_vld_reg;
    logic [OW-1:0]       res_i_reg, res_q_reg;
    logic [2*OW-1:0]     m_data_reg;
    logic                m_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == cfir_pkg::ADDR_TAP_COUNT) ? 32'(tap_count_reg) : 32'd0;

    assign s_tready    = (state_reg == ST_IDLE) && !res_vld_reg;
    assign accept      = s_tvalid && s_tready;
    assign take_sample = accept && (s_tuser == cfir_pkg::ACT_SAMPLE);
    assign take_load   = accept && (s_tuser == cfir_pkg::ACT_LOAD);
    assign in_idx      = s_tdata[OFF_IX +: AW];

    always_comb begin
        if (tap_count_reg == '0) begin
            nsat = CNT_W'(1);
        end else if (tap_count_reg > CNT_W'(MAX_TAPS)) begin
            nsat = CNT_W'(MAX_TAPS);
        end else begin
            nsat = tap_count_reg;
        end
        nm1    = nsat - CNT_W'(1);
        n_last = nm1[AW-1:0];
        wpn    = (wp_reg == AW'(MAX_TAPS - 1)) ? '0 : wp_reg + AW'(1);
        wpn_e  = {1'b0, wpn};
        n_e    = PW'(nsat);
        if (wpn_e >= n_e) begin
            pos_e = wpn_e - n_e;
        end else begin
            pos_e = wpn_e + PW'(MAX_TAPS) - n_e;
        end
        pos_start = pos_e[AW-1:0];
    end

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            line_we    = 1'b1;
            line_waddr = clr_reg;
            line_wdata = '0;
            coef_we    = 1'b1;
            coef_waddr = clr_reg;
            coef_wdata = '0;
        end else begin
            line_we    = take_sample;
            line_waddr = wp_reg;
            line_wdata = {s_tdata[OFF_Q +: SW], s_tdata[SW-1:0]};
            coef_we    = take_load && ({1'b0, in_idx} < PW'(MAX_TAPS));
            coef_waddr = in_idx;
            coef_wdata = {s_tdata[OFF_IM +: CW], s_tdata[OFF_RE +: CW]};
        end
    end

    always_comb begin
        issue_ctl.vld   = (state_reg == ST_RUN);
        issue_ctl.first = (k_reg == '0);
        issue_ctl.last  = (k_reg == n_last_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == AW'(MAX_TAPS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (take_sample) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (k_reg == n_last_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_vld) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_free = !m_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            tap_count_reg <= CNT_W'(MAX_TAPS);
            clr_reg       <= '0;
            wp_reg        <= '0;
            ctl_d_reg     <= '0;
            res_vld_reg   <= 1'b0;
            m_vld_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            ctl_d_reg <= issue_ctl;
            if (cfg_wr && (paddr == cfir_pkg::ADDR_TAP_COUNT)) begin
                tap_count_reg <= pwdata[CNT_W-1:0];
            end
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (take_sample) begin
                wp_reg <= wpn;
            end
            if (mac_vld) begin
                res_vld_reg <= 1'b1;
            end else if (res_vld_reg && m_free) begin
                res_vld_reg <= 1'b0;
            end
            if (res_vld_reg && m_free) begin
                m_vld_reg <= 1'b1;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
        end
        if (take_sample) begin
            pos_reg    <= pos_start;
            k_reg      <= '0;
            n_last_reg <= n_last;
        end else if (state_reg == ST_RUN) begin
            pos_reg <= (pos_reg == AW'(MAX_TAPS - 1)) ? '0 : pos_reg + AW'(1);
            k_reg   <= k_reg + AW'(1);
        end
        if (mac_vld) begin
            res_i_reg <= mac_i;
            res_q_reg <= mac_q;
        end
        if (res_vld_reg && m_free) begin
            m_data_reg <= {res_q_reg, res_i_reg};
        end
    end

    cfir_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_TAPS)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (pos_reg),
        .rdata (line_rdata)
    );

    cfir_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (k_reg),
        .rdata (coef_rdata)
    );

    cfir_mac #(
        .SAMPLE_WIDTH (SW),
        .COEF_WIDTH   (CW),
        .MAX_TAPS     (MAX_TAPS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl_d_reg),
        .xi      (line_rdata[SW-1:0]),
        .xq      (line_rdata[2*SW-1:SW]),
        .cr      (coef_rdata[CW-1:0]),
        .ci      (coef_rdata[2*CW-1:CW]),
        .out_vld (mac_vld),
        .out_i   (mac_i),
        .out_q   (mac_q)
    );

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

endmodule
